// ===== design/bm25ds_pkg.sv =====
// Shared widths, reset values and register map of the BM25 document scorer.
// No dependencies; used by bm25_document_scorer, bm25ds_checker and the testbench.
`default_nettype none

package bm25ds_pkg;

   localparam int DOC_W   = 24;
   localparam int LEN_W   = 20;
   localparam int DF_W    = 24;
   localparam int TFD_W   = 16;
   localparam int TFQ_W   = 8;
   localparam int SCORE_W = 32;
   localparam int SUM_W   = 40;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;

   localparam int K1_W  = 10;
   localparam int K2_W  = 16;
   localparam int B_W   = 9;
   localparam int N_W   = 24;
   localparam int AVG_W = 28;

   localparam logic [K1_W-1:0]  K1_RST  = 10'd307;
   localparam logic [K2_W-1:0]  K2_RST  = 16'd25600;
   localparam logic [B_W-1:0]   B_RST   = 9'd192;
   localparam logic [N_W-1:0]   N_RST   = 24'd1048576;
   localparam logic [AVG_W-1:0] AVG_RST = 28'd256;

   // log10(2) as unsigned Q0.32
   localparam logic [31:0] LOG10_2_Q32 = 32'd1292913987;

   localparam logic [2:0] REG_K1  = 3'd0;
   localparam logic [2:0] REG_K2  = 3'd1;
   localparam logic [2:0] REG_B   = 3'd2;
   localparam logic [2:0] REG_N   = 3'd3;
   localparam logic [2:0] REG_AVG = 3'd4;

endpackage

`default_nettype wire

// ===== design/bm25_document_scorer.sv =====
// BM25 document scorer: sequencer, shared 32x32 multiplier, bit-serial divider.
// Depends on bm25ds_pkg.
`default_nettype none

// One posting is taken per transfer on req_*; req_stall is high while it is
// being scored. Each posting adds idf * tf_factor * qtf_factor to a saturating
// 40-bit signed Q24.16 sum; a posting with req_last_term set produces one rsp_*
// transfer carrying the sum saturated to signed Q16.16, and clears the sum.
// Each posting runs through two base-2 logarithms (a one-bit-per-cycle
// normalizing shift, then 16 squaring steps on the shared multiplier),
// three restoring divisions that produce one quotient bit per cycle, and
// the multiply and accumulate steps for idf, b*dl, k1*norm, the two factor
// numerators, the term weight and the sum; the divisions take most of the time.
// A finished result sits in the output register while the next posting is
// already taken; only a second last-term posting waits for it to drain.
// Registers sit on an APB-style port at byte addresses 0,4,8,12,16
// (k1, k2, b, num_docs, avg_doc_len); write them only while the block is idle.
module bm25_document_scorer (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire [bm25ds_pkg::DOC_W-1:0]       req_doc_number,
   input  wire [bm25ds_pkg::LEN_W-1:0]       req_doc_length,
   input  wire [bm25ds_pkg::DF_W-1:0]        req_doc_freq,
   input  wire [bm25ds_pkg::TFD_W-1:0]       req_term_freq_doc,
   input  wire [bm25ds_pkg::TFQ_W-1:0]       req_term_freq_query,
   input  wire                               req_last_term,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic signed [bm25ds_pkg::SCORE_W-1:0] rsp_score,
   output logic [bm25ds_pkg::DOC_W-1:0]      rsp_scored_doc,
   input  wire                               psel,
   input  wire                               penable,
   input  wire                               pwrite,
   input  wire [bm25ds_pkg::ADDR_W-1:0]      paddr,
   input  wire [bm25ds_pkg::DATA_W-1:0]      pwdata,
   output logic [bm25ds_pkg::DATA_W-1:0]     prdata,
   output logic                              pready
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_LG_SETUP, ST_LG_NORM, ST_LG_SQ, ST_IDF_DIFF, ST_IDF_MUL,
      ST_BDL, ST_DIV_NORM, ST_KLO, ST_KHI, ST_TFNUM, ST_DIV_TF, ST_QFNUM,
      ST_DIV_QF, ST_WMUL, ST_CMUL, ST_ACC
   } state_type;

   // config
   logic [bm25ds_pkg::K1_W-1:0]  k1_ff;
   logic [bm25ds_pkg::K2_W-1:0]  k2_ff;
   logic [bm25ds_pkg::B_W-1:0]   b_ff;
   logic [bm25ds_pkg::N_W-1:0]   n_ff;
   logic [bm25ds_pkg::AVG_W-1:0] avg_ff;

   state_type state_ff, state_in;

   // posting
   logic [23:0] doc_ff, doc_in;
   logic [19:0] dl_ff, dl_in;
   logic [23:0] df_ff, df_in;
   logic [15:0] tfd_ff, tfd_in;
   logic [7:0]  tfq_ff, tfq_in;
   logic        last_ff, last_in;

   // logarithm
   logic        lg_sel_ff, lg_sel_in;
   logic [31:0] m_ff, m_in;
   logic [4:0]  sh_ff, sh_in;
   logic [4:0]  r_int_ff, r_int_in;
   logic [15:0] r_frac_ff, r_frac_in;
   logic [3:0]  bit_ff, bit_in;
   logic [20:0] la_ff, la_in, lb_ff, lb_in;
   logic [20:0] dmag_ff, dmag_in, idf_mag_ff, idf_mag_in;
   logic        idf_neg_ff, idf_neg_in;

   // divider
   logic [51:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;

   // factors
   logic [45:0] norm_ff, norm_in;
   logic [41:0] kacc_ff, kacc_in;
   logic [47:0] kq_ff, kq_in;
   logic [18:0] tf_ff, tf_in;
   logic [23:0] qf_ff, qf_in;
   logic [26:0] w_ff, w_in;
   logic [31:0] cmag_ff, cmag_in;
   logic signed [39:0] sum_ff, sum_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] score_ff, score_in;
   logic [23:0] sdoc_ff, sdoc_in;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;

   logic [8:0]  b_eff;
   logic [27:0] avg_eff;
   logic [24:0] lg_num, lg_den;
   logic [31:0] sq;
   logic [52:0] shifted, diff;
   logic        ge;
   logic [51:0] quo_step, qv;
   logic [55:0] ksum;
   logic signed [40:0] s41;
   logic signed [39:0] s40;
   logic        wr;

   assign b_eff   = (b_ff > 9'd256) ? 9'd256 : b_ff;
   assign avg_eff = (avg_ff == '0) ? 28'd1 : avg_ff;
   assign lg_num  = (25'(n_ff) << 1) - (25'(df_ff) << 1) + 25'd1;
   assign lg_den  = (25'(df_ff) << 1) + 25'd1;

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_score      = score_ff;
   assign rsp_scored_doc = sdoc_ff;
   assign pready         = 1'b1;
   assign wr             = psel & penable & pwrite;

   always_comb begin
      unique case (paddr[4:2])
         bm25ds_pkg::REG_K1:  prdata = 32'(k1_ff);
         bm25ds_pkg::REG_K2:  prdata = 32'(k2_ff);
         bm25ds_pkg::REG_B:   prdata = 32'(b_ff);
         bm25ds_pkg::REG_N:   prdata = 32'(n_ff);
         bm25ds_pkg::REG_AVG: prdata = 32'(avg_ff);
         default:             prdata = '0;
      endcase
   end

   always_comb begin
      mul_a = m_ff;
      mul_b = m_ff;
      case (state_ff)
         ST_IDF_MUL: begin
            mul_a = 32'(dmag_ff);
            mul_b = bm25ds_pkg::LOG10_2_Q32;
         end
         ST_BDL: begin
            mul_a = 32'(b_eff);
            mul_b = 32'(dl_ff);
         end
         ST_KLO: begin
            mul_a = 32'(k1_ff);
            mul_b = norm_ff[31:0];
         end
         ST_KHI: begin
            mul_a = 32'(k1_ff);
            mul_b = 32'(norm_ff[45:32]);
         end
         ST_TFNUM: begin
            mul_a = 32'(k1_ff) + 32'd256;
            mul_b = 32'(tfd_ff);
         end
         ST_QFNUM: begin
            mul_a = 32'(k2_ff) + 32'd256;
            mul_b = 32'(tfq_ff);
         end
         ST_WMUL: begin
            mul_a = 32'(tf_ff);
            mul_b = 32'(qf_ff);
         end
         ST_CMUL: begin
            mul_a = 32'(idf_mag_ff);
            mul_b = 32'(w_ff);
         end
         default: ;
      endcase
   end

   assign prod = 64'(mul_a) * 64'(mul_b);
   assign sq   = prod[61:30];

   // restoring divide step, one quotient bit per cycle
   assign shifted  = {rem_ff, quo_ff[51]};
   assign diff     = shifted - {1'b0, dvs_ff};
   assign ge       = (shifted >= {1'b0, dvs_ff});
   assign quo_step = {quo_ff[50:0], ge};
   assign qv       = (dvs_ff == '0) ? '0 : quo_step;

   assign ksum = 56'(kacc_ff) + (56'(prod[23:0]) << 32);
   assign s41  = idf_neg_ff ? (41'(sum_ff) - 41'(signed'({9'd0, cmag_ff})))
                            : (41'(sum_ff) + 41'(signed'({9'd0, cmag_ff})));

   always_comb begin
      if (s41[40] != s41[39]) begin
         s40 = s41[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
      end else begin
         s40 = s41[39:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      doc_in       = doc_ff;
      dl_in        = dl_ff;
      df_in        = df_ff;
      tfd_in       = tfd_ff;
      tfq_in       = tfq_ff;
      last_in      = last_ff;
      lg_sel_in    = lg_sel_ff;
      m_in         = m_ff;
      sh_in        = sh_ff;
      r_int_in     = r_int_ff;
      r_frac_in    = r_frac_ff;
      bit_in       = bit_ff;
      la_in        = la_ff;
      lb_in        = lb_ff;
      dmag_in      = dmag_ff;
      idf_mag_in   = idf_mag_ff;
      idf_neg_in   = idf_neg_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvs_in       = dvs_ff;
      cnt_in       = cnt_ff;
      norm_in      = norm_ff;
      kacc_in      = kacc_ff;
      kq_in        = kq_ff;
      tf_in        = tf_ff;
      qf_in        = qf_ff;
      w_in         = w_ff;
      cmag_in      = cmag_ff;
      sum_in       = sum_ff;
      score_in     = score_ff;
      sdoc_in      = sdoc_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      if (state_ff == ST_DIV_NORM || state_ff == ST_DIV_TF || state_ff == ST_DIV_QF) begin
         rem_in = ge ? diff[51:0] : shifted[51:0];
         quo_in = quo_step;
         cnt_in = cnt_ff - 6'd1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               doc_in    = req_doc_number;
               dl_in     = req_doc_length;
               df_in     = (req_doc_freq > n_ff) ? n_ff : req_doc_freq;
               tfd_in    = req_term_freq_doc;
               tfq_in    = req_term_freq_query;
               last_in   = req_last_term;
               lg_sel_in = 1'b0;
               state_in  = ST_LG_SETUP;
            end
         end
         ST_LG_SETUP: begin
            m_in     = lg_sel_ff ? 32'(lg_den) : 32'(lg_num);
            sh_in    = '0;
            state_in = ST_LG_NORM;
         end
         ST_LG_NORM: begin
            if (m_ff[30]) begin
               r_int_in  = 5'd30 - sh_ff;
               r_frac_in = '0;
               bit_in    = 4'd15;
               state_in  = ST_LG_SQ;
            end else begin
               m_in  = m_ff << 1;
               sh_in = sh_ff + 5'd1;
            end
         end
         ST_LG_SQ: begin
            if (sq[31]) begin
               m_in              = {1'b0, sq[31:1]};
               r_frac_in[bit_ff] = 1'b1;
            end else begin
               m_in = sq;
            end
            if (bit_ff == 4'd0) begin
               if (!lg_sel_ff) begin
                  la_in     = {r_int_ff, r_frac_in};
                  lg_sel_in = 1'b1;
                  state_in  = ST_LG_SETUP;
               end else begin
                  lb_in    = {r_int_ff, r_frac_in};
                  state_in = ST_IDF_DIFF;
               end
            end else begin
               bit_in = bit_ff - 4'd1;
            end
         end
         ST_IDF_DIFF: begin
            idf_neg_in = (la_ff < lb_ff);
            dmag_in    = (la_ff < lb_ff) ? (lb_ff - la_ff) : (la_ff - lb_ff);
            state_in   = ST_IDF_MUL;
         end
         ST_IDF_MUL: begin
            idf_mag_in = 21'((prod + 64'h8000_0000) >> 32);
            state_in   = ST_BDL;
         end
         ST_BDL: begin
            quo_in   = 52'(prod[28:0]) << 16;
            dvs_in   = 52'(avg_eff);
            rem_in   = '0;
            cnt_in   = 6'd51;
            state_in = ST_DIV_NORM;
         end
         ST_DIV_NORM: begin
            if (cnt_ff == 6'd0) begin
               norm_in  = 46'({9'd256 - b_eff, 8'd0}) + qv[45:0];
               state_in = ST_KLO;
            end
         end
         ST_KLO: begin
            kacc_in  = prod[41:0];
            state_in = ST_KHI;
         end
         ST_KHI: begin
            kq_in    = ksum[55:8];
            state_in = ST_TFNUM;
         end
         ST_TFNUM: begin
            quo_in   = 52'(prod[26:0]) << 24;
            dvs_in   = 52'(kq_ff) + (52'(tfd_ff) << 16);
            rem_in   = '0;
            cnt_in   = 6'd51;
            state_in = ST_DIV_TF;
         end
         ST_DIV_TF: begin
            if (cnt_ff == 6'd0) begin
               tf_in    = qv[18:0];
               state_in = ST_QFNUM;
            end
         end
         ST_QFNUM: begin
            quo_in   = 52'(prod[24:0]) << 16;
            dvs_in   = 52'(k2_ff) + (52'(tfq_ff) << 8);
            rem_in   = '0;
            cnt_in   = 6'd51;
            state_in = ST_DIV_QF;
         end
         ST_DIV_QF: begin
            if (cnt_ff == 6'd0) begin
               qf_in    = qv[23:0];
               state_in = ST_WMUL;
            end
         end
         ST_WMUL: begin
            w_in     = prod[42:16];
            state_in = ST_CMUL;
         end
         ST_CMUL: begin
            cmag_in  = prod[47:16];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (!last_ff) begin
               sum_in   = s40;
               state_in = ST_IDLE;
            end else if (!(rsp_valid_ff && rsp_stall)) begin
               // saturate the 40-bit sum into signed Q16.16
               if (s40[39:31] != {9{s40[39]}}) begin
                  score_in = s40[39] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
               end else begin
                  score_in = s40[31:0];
               end
               sdoc_in      = doc_ff;
               rsp_valid_in = 1'b1;
               sum_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      doc_ff     <= doc_in;
      dl_ff      <= dl_in;
      df_ff      <= df_in;
      tfd_ff     <= tfd_in;
      tfq_ff     <= tfq_in;
      last_ff    <= last_in;
      lg_sel_ff  <= lg_sel_in;
      m_ff       <= m_in;
      sh_ff      <= sh_in;
      r_int_ff   <= r_int_in;
      r_frac_ff  <= r_frac_in;
      bit_ff     <= bit_in;
      la_ff      <= la_in;
      lb_ff      <= lb_in;
      dmag_ff    <= dmag_in;
      idf_mag_ff <= idf_mag_in;
      idf_neg_ff <= idf_neg_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      dvs_ff     <= dvs_in;
      cnt_ff     <= cnt_in;
      norm_ff    <= norm_in;
      kacc_ff    <= kacc_in;
      kq_ff      <= kq_in;
      tf_ff      <= tf_in;
      qf_ff      <= qf_in;
      w_ff       <= w_in;
      cmag_ff    <= cmag_in;
      score_ff   <= score_in;
      sdoc_ff    <= sdoc_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         k1_ff        <= bm25ds_pkg::K1_RST;
         k2_ff        <= bm25ds_pkg::K2_RST;
         b_ff         <= bm25ds_pkg::B_RST;
         n_ff         <= bm25ds_pkg::N_RST;
         avg_ff       <= bm25ds_pkg::AVG_RST;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr) begin
            unique case (paddr[4:2])
               bm25ds_pkg::REG_K1:  k1_ff  <= pwdata[9:0];
               bm25ds_pkg::REG_K2:  k2_ff  <= pwdata[15:0];
               bm25ds_pkg::REG_B:   b_ff   <= pwdata[8:0];
               bm25ds_pkg::REG_N:   n_ff   <= pwdata[23:0];
               bm25ds_pkg::REG_AVG: avg_ff <= pwdata[27:0];
               default: ;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/bm25ds_checker.sv =====
// Port-level checks for bm25_document_scorer, attached by bind.
// Depends on bm25ds_pkg.
`default_nettype none

module bm25ds_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               req_valid,
   input wire                               req_stall,
   input wire                               rsp_valid,
   input wire                               rsp_stall,
   input wire [bm25ds_pkg::SCORE_W-1:0]     rsp_score,
   input wire [bm25ds_pkg::DOC_W-1:0]       rsp_scored_doc,
   input wire                               pready
);

   // held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_score) && $stable(rsp_scored_doc))
      else $error("stalled result changed");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("reset left result or busy set");

   // one posting at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !$rose(rsp_valid))
      else $error("posting not held busy");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready dropped");

endmodule

bind bm25_document_scorer bm25ds_checker u_bm25ds_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_score(rsp_score),
   .rsp_scored_doc(rsp_scored_doc), .pready(pready)
);

`default_nettype wire

// ===== tb/bm25_document_scorer_tb.sv =====
// Self-checking testbench for bm25_document_scorer: postings in, document scores out.
// Depends on bm25ds_pkg and the bm25_document_scorer RTL.
`default_nettype none

module bm25_document_scorer_tb;

   localparam int DOC_W   = bm25ds_pkg::DOC_W;
   localparam int LEN_W   = bm25ds_pkg::LEN_W;
   localparam int DF_W    = bm25ds_pkg::DF_W;
   localparam int TFD_W   = bm25ds_pkg::TFD_W;
   localparam int TFQ_W   = bm25ds_pkg::TFQ_W;
   localparam int SCORE_W = bm25ds_pkg::SCORE_W;
   localparam int ADDR_W  = bm25ds_pkg::ADDR_W;
   localparam int DATA_W  = bm25ds_pkg::DATA_W;
   localparam int K1_W    = bm25ds_pkg::K1_W;
   localparam int K2_W    = bm25ds_pkg::K2_W;
   localparam int B_W     = bm25ds_pkg::B_W;
   localparam int N_W     = bm25ds_pkg::N_W;
   localparam int AVG_W   = bm25ds_pkg::AVG_W;

   localparam logic [K1_W-1:0]  K1_RST  = bm25ds_pkg::K1_RST;
   localparam logic [K2_W-1:0]  K2_RST  = bm25ds_pkg::K2_RST;
   localparam logic [B_W-1:0]   B_RST   = bm25ds_pkg::B_RST;
   localparam logic [N_W-1:0]   N_RST   = bm25ds_pkg::N_RST;
   localparam logic [AVG_W-1:0] AVG_RST = bm25ds_pkg::AVG_RST;
   localparam logic [31:0]      LOG10_2_Q32 = bm25ds_pkg::LOG10_2_Q32;

   localparam logic [2:0] REG_K1  = bm25ds_pkg::REG_K1;
   localparam logic [2:0] REG_K2  = bm25ds_pkg::REG_K2;
   localparam logic [2:0] REG_B   = bm25ds_pkg::REG_B;
   localparam logic [2:0] REG_N   = bm25ds_pkg::REG_N;
   localparam logic [2:0] REG_AVG = bm25ds_pkg::REG_AVG;

   // one posting as driven on req_*
   typedef struct {
      logic [DOC_W-1:0] doc;
      logic [LEN_W-1:0] len;
      logic [DF_W-1:0]  df;
      logic [TFD_W-1:0] tfd;
      logic [TFQ_W-1:0] tfq;
      logic             last;
   } posting_type;

   // one document score as seen on rsp_*
   typedef struct {
      logic signed [SCORE_W-1:0] score;
      logic [DOC_W-1:0]          doc;
   } doc_score_type;

   localparam longint SUM_HI = 64'sd549755813887;
   localparam longint SUM_LO = -64'sd549755813888;
   // settle margin before register writes
   localparam int SETTLE_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [DOC_W-1:0]     req_doc_number = '0;
   logic [LEN_W-1:0]     req_doc_length = '0;
   logic [DF_W-1:0]      req_doc_freq = '0;
   logic [TFD_W-1:0]     req_term_freq_doc = '0;
   logic [TFQ_W-1:0]     req_term_freq_query = '0;
   logic                 req_last_term = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic signed [SCORE_W-1:0] rsp_score;
   logic [DOC_W-1:0]     rsp_scored_doc;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [ADDR_W-1:0]    paddr = '0;
   logic [DATA_W-1:0]    pwdata = '0;
   logic [DATA_W-1:0]    prdata;
   logic                 pready;

   posting_type   postings_pending[$];
   doc_score_type scores_expected[$];
   int            error_count = 0;

   // shadow copies of the block's registers and running sum
   logic [K1_W-1:0]  sh_k1;
   logic [K2_W-1:0]  sh_k2;
   logic [B_W-1:0]   sh_b;
   logic [N_W-1:0]   sh_n;
   logic [AVG_W-1:0] sh_avg;
   longint           doc_sum;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   bm25_document_scorer u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_doc_number      (req_doc_number),
      .req_doc_length      (req_doc_length),
      .req_doc_freq        (req_doc_freq),
      .req_term_freq_doc   (req_term_freq_doc),
      .req_term_freq_query (req_term_freq_query),
      .req_last_term       (req_last_term),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_score           (rsp_score),
      .rsp_scored_doc      (rsp_scored_doc),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   // log2 in Q16: integer part from the leading one, fraction by repeated
   // squaring of a Q1.30 mantissa, each square truncated
   function automatic logic [31:0] log2_q16(logic [63:0] x);
      int          e;
      logic [63:0] t;
      logic [63:0] m;
      logic [31:0] r;
      e = 0;
      t = x;
      while (t > 1) begin
         t = t >> 1;
         e++;
      end
      m = x << (30 - e);
      r = 32'(e) << 16;
      for (int i = 15; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= 64'h8000_0000) begin
            m = m >> 1;
            r[i] = 1'b1;
         end
      end
      return r;
   endfunction

   // Adds one posting's BM25 term weight to doc_sum; on the last posting
   // yields the saturated Q16.16 document score and clears the sum.
   function automatic bit score_posting(posting_type p, output doc_score_type res);
      logic [63:0] n, df, b, avg, la, lb, dmag, idf_mag;
      logic [63:0] norm, kq, den, tf, qf, w, cmag;
      logic        neg;
      longint      s;
      n   = 64'(sh_n);
      df  = (64'(p.df) > n) ? n : 64'(p.df);           // freq above collection size
      b   = (sh_b > 9'd256) ? 64'd256 : 64'(sh_b);      // weight b above one
      avg = (sh_avg == '0) ? 64'd1 : 64'(sh_avg);       // zero average length
      la  = 64'(log2_q16(2 * n - 2 * df + 1));
      lb  = 64'(log2_q16(2 * df + 1));
      neg = la < lb;
      dmag = neg ? lb - la : la - lb;
      idf_mag = (dmag * 64'(LOG10_2_Q32) + (64'd1 << 31)) >> 32;

      norm = ((64'd256 - b) << 8) + ((b * 64'(p.len)) << 16) / avg;
      kq   = (64'(sh_k1) * norm) >> 8;
      den  = kq + (64'(p.tfd) << 16);
      tf   = (den == 0) ? 64'd0 : (((64'(sh_k1) + 256) * 64'(p.tfd)) << 24) / den;
      den  = 64'(sh_k2) + (64'(p.tfq) << 8);
      qf   = (den == 0) ? 64'd0 : (((64'(sh_k2) + 256) * 64'(p.tfq)) << 16) / den;
      w    = (tf * qf) >> 16;
      cmag = (idf_mag * w) >> 16;

      s = neg ? doc_sum - longint'(cmag) : doc_sum + longint'(cmag);
      if (s > SUM_HI) s = SUM_HI;
      if (s < SUM_LO) s = SUM_LO;
      doc_sum = s;
      res.doc = p.doc;
      res.score = '0;
      if (!p.last) return 1'b0;
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      res.score = 32'(s);
      doc_sum = 0;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: bursts of random length separated by random gaps.
   // The payload is held steady while stalled; prediction happens on the
   // accepting edge from the values that were on the bus at that edge.
   // ---------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      posting_type   p;
      doc_score_type res;
      bit            took;
      took = req_valid && !req_stall;
      if (took) begin
         p = postings_pending.pop_front();
         if (score_posting(p, res))
            scores_expected.insert(scores_expected.size(), res);
      end
      if (!req_valid || took) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (postings_pending.size() > 0) begin
            p = postings_pending[0];
            req_valid           <= 1'b1;
            req_doc_number      <= p.doc;
            req_doc_length      <= p.len;
            req_doc_freq        <= p.df;
            req_term_freq_doc   <= p.tfd;
            req_term_freq_query <= p.tfq;
            req_last_term       <= p.last;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               // end of burst: pick the next burst and the gap in front of it
               burst_left = $urandom_range(0, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response stall pattern: modes of none, light and heavy stalling,
   // each held for a random number of cycles.
   // ---------------------------------------------------------------------
   int stall_mode = 0;
   int mode_left  = 0;

   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left = $urandom_range(50, 2000);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_stall <= ($urandom_range(0, 3) != 0);
         end
      endcase
   end

   // Result monitor: every transfer on rsp_* is checked against the oldest expectation.
   always @(posedge clock) begin
      doc_score_type exp_s;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (scores_expected.size() == 0) begin
            $error("unexpected score transfer: doc %0d score %0d", rsp_scored_doc, rsp_score);
            error_count++;
         end else begin
            exp_s = scores_expected.pop_front();
            if (rsp_score !== exp_s.score) begin
               $error("score: expected %0d actual %0d", exp_s.score, rsp_score);
               error_count++;
            end
            if (rsp_scored_doc !== exp_s.doc) begin
               $error("scored_doc: expected %0d actual %0d", exp_s.doc, rsp_scored_doc);
               error_count++;
            end
         end
      end
   end

   // Register write: setup cycle, then access cycle; the register takes the
   // value at the edge that closes the access cycle.
   task automatic csr_write(logic [2:0] idx, logic [DATA_W-1:0] val);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_K1:  sh_k1  = val[K1_W-1:0];
         REG_K2:  sh_k2  = val[K2_W-1:0];
         REG_B:   sh_b   = val[B_W-1:0];
         REG_N:   sh_n   = val[N_W-1:0];
         REG_AVG: sh_avg = val[AVG_W-1:0];
         default: ;   // unmapped address, ignored
      endcase
   endtask

   task automatic set_params(int k1, int k2, int b, int n, int avg);
      csr_write(REG_K1, k1);
      csr_write(REG_K2, k2);
      csr_write(REG_B, b);
      csr_write(REG_N, n);
      csr_write(REG_AVG, avg);
   endtask

   task automatic add_posting(int doc, int len, int df, int tfd, int tfq, bit last);
      posting_type p;
      p.doc  = DOC_W'(doc);
      p.len  = LEN_W'(len);
      p.df   = DF_W'(df);
      p.tfd  = TFD_W'(tfd);
      p.tfq  = TFQ_W'(tfq);
      p.last = last;
      postings_pending.insert(postings_pending.size(), p);
   endtask

   // random value of up to w bits with a random effective width, so small
   // and full-width values both show up
   function automatic int rand_bits(int w);
      int k;
      k = $urandom_range(1, w);
      return int'($urandom() & ((64'd1 << k) - 1));
   endfunction

   // Random documents: 1..6 postings, last_term only on the final one.
   task automatic add_documents(int count);
      int terms, df;
      for (int d = 0; d < count; d++) begin
         terms = $urandom_range(1, 6);
         for (int t = 0; t < terms; t++) begin
            case ($urandom_range(0, 3))
               0: df = $urandom_range(1, 16);
               1: df = int'(sh_n) + $urandom_range(0, 1000);  // at or above collection size
               default: df = rand_bits(DF_W);
            endcase
            if (df == 0) df = 1;
            if (df > 24'hFFFFFF) df = 24'hFFFFFF;
            add_posting(int'($urandom() & 24'hFFFFFF), rand_bits(LEN_W), df,
                        rand_bits(TFD_W) | 1 << $urandom_range(0, 15) & 0 | 1,
                        rand_bits(TFQ_W) | 1, t == terms - 1);
         end
      end
   endtask

   // Drains all outstanding work before the registers may be touched again.
   task automatic drain();
      wait (postings_pending.size() == 0 && !req_valid && scores_expected.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      sh_k1 = K1_RST; sh_k2 = K2_RST; sh_b = B_RST; sh_n = N_RST; sh_avg = AVG_RST;
      doc_sum = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed, reset settings: field extremes and special cases
      add_posting(0, 0, 1, 1, 1, 1);
      add_posting(24'hFFFFFF, 20'hFFFFF, 24'hFFFFFF, 16'hFFFF, 8'hFF, 1);   // df above N
      add_posting(1, 100, 1, 65535, 255, 0);                                 // accumulate
      add_posting(1, 100, 524288, 3, 2, 0);                                  // idf of zero
      add_posting(1, 100, 1048576, 7, 9, 1);                                 // negative idf
      add_posting(2, 1, 2, 1, 1, 0);
      for (int i = 0; i < 8; i++)
         add_posting(3, 0, 1, 16'hFFFF, 8'hFF, i == 7);                      // push the sum high
      drain();

      // extreme register settings: k1, k2 and b zero, num_docs and avg_doc_len one
      set_params(0, 0, 0, 1, 1);
      add_posting(4, 0, 1, 1, 1, 1);
      add_posting(5, 20'hFFFFF, 24'hFFFFFF, 16'hFFFF, 8'hFF, 1);
      add_documents(10);
      drain();

      // top of every range, b above one, and an unmapped register address
      set_params(1023, 65535, 511, 24'hFFFFFF, 28'hFFFFFFF);
      csr_write(3'd7, 32'hFFFF_FFFF);
      add_posting(6, 20'hFFFFF, 1, 16'hFFFF, 8'hFF, 0);
      add_posting(6, 0, 24'hFFFFFF, 1, 1, 1);
      add_documents(25);
      drain();

      // zero average length, b exactly one
      set_params(256, 256, 256, 1000, 0);
      add_documents(25);
      drain();

      // reset k1, k2 and b with maximum num_docs, many documents with large contributions
      set_params(307, 25600, 192, 16777215, 2560);
      add_documents(35);
      drain();

      set_params($urandom_range(0, 1023), $urandom_range(0, 65535), $urandom_range(0, 256),
                 $urandom_range(1, 24'hFFFFFF), $urandom_range(1, 28'hFFFFFFF));
      add_documents(35);
      drain();

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire

// ===== bm25_document_scorer.f =====
design/bm25ds_pkg.sv
design/bm25_document_scorer.sv
design/bm25ds_checker.sv
tb/bm25_document_scorer_tb.sv
